FILE: hdl/ptrim_pkg.sv
// Package for the polyline end overshoot trim unit.
// Holds sizes, the vertex type and the control state encoding; no dependencies.
`default_nettype none

package ptrim_pkg;

    localparam int PT_WINDOW     = 20;
    localparam int PT_COORD_BITS = 24;
    localparam int PT_TAIL_CAP   = PT_WINDOW - 2;
    localparam int PT_THR_W      = 49;
    localparam int PT_DIST_W     = 2 * PT_COORD_BITS + 1;
    localparam int PT_CMP_W      = (PT_DIST_W > PT_THR_W) ? PT_DIST_W : PT_THR_W;
    localparam int PT_HCNT_W     = $clog2(PT_WINDOW + 1);
    localparam int PT_HIDX_W     = $clog2(PT_WINDOW);
    localparam int PT_TCNT_W     = $clog2(PT_TAIL_CAP + 1);
    localparam int PT_TIDX_W     = (PT_TAIL_CAP > 1) ? $clog2(PT_TAIL_CAP) : 1;

    typedef struct packed {
        logic signed [PT_COORD_BITS-1:0] x;
        logic signed [PT_COORD_BITS-1:0] y;
    } t_vtx;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DEC   = 12'b0000_0000_0010,
        S_HWAIT = 12'b0000_0000_0100,
        S_RADM0 = 12'b0000_0000_1000,
        S_RRD   = 12'b0000_0001_0000,
        S_RADM  = 12'b0000_0010_0000,
        S_FIN   = 12'b0000_0100_0000,
        S_TSRT  = 12'b0000_1000_0000,
        S_TWAIT = 12'b0001_0000_0000,
        S_TSTEP = 12'b0010_0000_0000,
        S_EMIT  = 12'b0100_0000_0000,
        S_ELAST = 12'b1000_0000_0000
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/ptrim_cell.sv
// One cell of the tail chain: holds one pending vertex.
// Loads a new vertex or takes its right neighbor's on a shift; uses ptrim_pkg.
`default_nettype none

module ptrim_cell (
    input  wire logic           i_clk,
    input  wire logic           i_shift,
    input  wire logic           i_load,
    input  wire ptrim_pkg::t_vtx i_data,
    input  wire ptrim_pkg::t_vtx i_next,
    output ptrim_pkg::t_vtx     o_data
);

    ptrim_pkg::t_vtx r_data;
    ptrim_pkg::t_vtx n_data;

    always_comb begin
        n_data = r_data;
        if (i_load) begin
            n_data = i_data;
        end else if (i_shift) begin
            n_data = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: hdl/ptrim_dist.sv
// Three-stage squared distance pipe: absolute differences, squares, sum.
// Uses ptrim_pkg for the vertex type and widths.
`default_nettype none

module ptrim_dist (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire ptrim_pkg::t_vtx             i_a,
    input  wire ptrim_pkg::t_vtx             i_b,
    output logic                             o_done,
    output logic [ptrim_pkg::PT_DIST_W-1:0]  o_dist
);

    localparam int CB = ptrim_pkg::PT_COORD_BITS;

    logic signed [CB:0]        w_dx;
    logic signed [CB:0]        w_dy;
    logic signed [CB:0]        w_ax;
    logic signed [CB:0]        w_ay;
    logic [CB-1:0]             r_mx;
    logic [CB-1:0]             r_my;
    logic [2*CB-1:0]           r_sx;
    logic [2*CB-1:0]           r_sy;
    logic [ptrim_pkg::PT_DIST_W-1:0] r_sum;
    logic [2:0]                r_vld;

    assign w_dx = (CB+1)'(i_a.x) - (CB+1)'(i_b.x);
    assign w_dy = (CB+1)'(i_a.y) - (CB+1)'(i_b.y);
    assign w_ax = w_dx[CB] ? -w_dx : w_dx;
    assign w_ay = w_dy[CB] ? -w_dy : w_dy;

    always_ff @(posedge i_clk) begin
        r_mx  <= w_ax[CB-1:0];
        r_my  <= w_ay[CB-1:0];
        r_sx  <= r_mx * r_mx;
        r_sy  <= r_my * r_my;
        r_sum <= ptrim_pkg::PT_DIST_W'(r_sx) + ptrim_pkg::PT_DIST_W'(r_sy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
    end

    assign o_done = r_vld[2];
    assign o_dist = r_sum;

endmodule

`default_nettype wire

FILE: hdl/polyline_end_overshoot_trim_unit.sv
// Polyline end overshoot trim, top level: control sequencer, head store,
// tail cell chain and output register. Uses ptrim_pkg, ptrim_cell, ptrim_dist.
//
// One item is taken at a time. A vertex inside the head window, other than the
// first one, goes through the three-stage distance pipe; the vertex that closes
// the head search also moves the kept head vertices into the tail chain one by
// one through the head store read port. The final vertex scans back through
// the tail chain, running the distance pipe for each vertex looked at (up to
// WINDOW-2), then streams the kept vertices out one per cycle while the output
// is not stalled.
`default_nettype none

module polyline_end_overshoot_trim_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic signed [ptrim_pkg::PT_COORD_BITS-1:0] i_in_x,
    input  wire logic signed [ptrim_pkg::PT_COORD_BITS-1:0] i_in_y,
    input  wire logic                                  i_in_last,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [ptrim_pkg::PT_COORD_BITS-1:0] o_out_x,
    output logic signed [ptrim_pkg::PT_COORD_BITS-1:0] o_out_y,
    output logic                                       o_out_last,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [ptrim_pkg::PT_THR_W-1:0]        i_cfg_data
);

    localparam int CAP = ptrim_pkg::PT_TAIL_CAP;
    localparam int HW  = ptrim_pkg::PT_HCNT_W;
    localparam int TW  = ptrim_pkg::PT_TCNT_W;
    localparam int QW  = ptrim_pkg::PT_TIDX_W;
    localparam int DW  = ptrim_pkg::PT_DIST_W;
    localparam int CW  = ptrim_pkg::PT_CMP_W;

    ptrim_pkg::t_state r_state;
    ptrim_pkg::t_state n_state;

    logic [ptrim_pkg::PT_THR_W-1:0] r_thr;
    ptrim_pkg::t_vtx r_v;
    logic            r_last;
    ptrim_pkg::t_vtx r_v0;
    ptrim_pkg::t_vtx r_hmem [ptrim_pkg::PT_WINDOW];
    ptrim_pkg::t_vtx r_rd;
    logic [HW-1:0]   r_hcnt;
    logic [HW-1:0]   r_best;
    logic [HW-1:0]   r_k;
    logic [HW-1:0]   r_upto;
    logic            r_fin;
    logic            r_hdone;
    logic [DW-1:0]   r_bdist;
    logic [TW-1:0]   r_tc;
    logic            r_evicted;
    logic [QW-1:0]   r_q;
    logic [QW-1:0]   r_tbest;
    logic            r_first;
    logic            r_out_valid;
    ptrim_pkg::t_vtx r_out;
    logic            r_out_last;

    ptrim_pkg::t_vtx w_cells [CAP];
    ptrim_pkg::t_vtx w_cell_q;
    ptrim_pkg::t_vtx w_adm_data;
    ptrim_pkg::t_vtx w_d_a;
    logic            w_slot;
    logic            w_accept;
    logic            w_adm_req;
    logic            w_adm_ok;
    logic            w_full;
    logic            w_emit;
    logic            w_shift;
    logic            w_elast;
    logic            w_d_start;
    logic            w_d_done;
    logic [DW-1:0]   w_dist;
    logic            w_over;
    logic [HW-1:0]   w_i;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ptrim_pkg::S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_slot      = !r_out_valid || !i_out_stall;
    assign w_full      = (r_tc == TW'(CAP));
    assign w_i         = r_hcnt - HW'(1);
    assign w_cell_q    = w_cells[r_q];
    assign w_over      = CW'(w_dist) > CW'(r_thr);

    assign w_adm_req  = (r_state == ptrim_pkg::S_RADM0) || (r_state == ptrim_pkg::S_RADM) ||
                        (r_state == ptrim_pkg::S_DEC && r_hdone && !r_last);
    assign w_adm_data = (r_state == ptrim_pkg::S_RADM0) ? r_v0 :
                        (r_state == ptrim_pkg::S_RADM) ? r_rd : r_v;
    assign w_adm_ok   = w_adm_req && (!w_full || w_slot);
    assign w_emit     = (r_state == ptrim_pkg::S_EMIT) && w_slot;
    assign w_elast    = (r_state == ptrim_pkg::S_ELAST) && w_slot;
    assign w_shift    = (w_adm_ok && w_full) || w_emit;

    assign w_d_start = (r_state == ptrim_pkg::S_TSRT) ||
                       (r_state == ptrim_pkg::S_DEC && !r_hdone && !r_last &&
                        r_hcnt != HW'(0));
    assign w_d_a     = (r_state == ptrim_pkg::S_TSRT) ? w_cell_q : r_v0;

    ptrim_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_d_start),
        .i_a     (w_d_a),
        .i_b     (r_v),
        .o_done  (w_d_done),
        .o_dist  (w_dist)
    );

    for (genvar j = 0; j < CAP; j++) begin : g_cell
        ptrim_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_load  ((w_adm_ok && w_full && j == CAP - 1) ||
                      (w_adm_ok && !w_full && r_tc == TW'(j))),
            .i_data  (w_adm_data),
            .i_next  (w_cells[(j == CAP - 1) ? j : j + 1]),
            .o_data  (w_cells[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ptrim_pkg::S_DEC && !r_hdone && !r_last) begin
            r_hmem[r_hcnt[ptrim_pkg::PT_HIDX_W-1:0]] <= r_v;
        end
        if (r_state == ptrim_pkg::S_RRD && r_k < r_upto) begin
            r_rd <= r_hmem[r_k[ptrim_pkg::PT_HIDX_W-1:0]];
        end
        if (w_accept) begin
            r_v    <= '{x: i_in_x, y: i_in_y};
            r_last <= i_in_last;
        end
        if (r_state == ptrim_pkg::S_DEC && !r_hdone && !r_last && r_hcnt == HW'(0)) begin
            r_v0 <= r_v;
        end
        if (w_shift && !(w_adm_ok && !w_full) || w_elast) begin
            r_out      <= w_elast ? r_v : w_cells[0];
            r_out_last <= w_elast;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ptrim_pkg::S_IDLE:  if (w_accept) n_state = ptrim_pkg::S_DEC;
            ptrim_pkg::S_DEC: begin
                if (r_hdone) begin
                    if (r_last) begin
                        n_state = ptrim_pkg::S_FIN;
                    end else if (w_adm_ok) begin
                        n_state = ptrim_pkg::S_IDLE;
                    end
                end else if (!r_last) begin
                    n_state = (r_hcnt == HW'(0)) ? ptrim_pkg::S_IDLE : ptrim_pkg::S_HWAIT;
                end else begin
                    n_state = (r_hcnt == HW'(0)) ? ptrim_pkg::S_ELAST : ptrim_pkg::S_RADM0;
                end
            end
            ptrim_pkg::S_HWAIT: begin
                if (w_d_done) begin
                    if (w_over || r_hcnt == HW'(ptrim_pkg::PT_WINDOW)) begin
                        n_state = ptrim_pkg::S_RADM0;
                    end else begin
                        n_state = ptrim_pkg::S_IDLE;
                    end
                end
            end
            ptrim_pkg::S_RADM0: if (w_adm_ok) n_state = ptrim_pkg::S_RRD;
            ptrim_pkg::S_RRD: begin
                if (r_k < r_upto) begin
                    n_state = ptrim_pkg::S_RADM;
                end else begin
                    n_state = r_fin ? ptrim_pkg::S_FIN : ptrim_pkg::S_IDLE;
                end
            end
            ptrim_pkg::S_RADM:  if (w_adm_ok) n_state = ptrim_pkg::S_RRD;
            ptrim_pkg::S_FIN: begin
                n_state = (r_tc == TW'(0)) ? ptrim_pkg::S_ELAST : ptrim_pkg::S_TSRT;
            end
            ptrim_pkg::S_TSRT:  n_state = ptrim_pkg::S_TWAIT;
            ptrim_pkg::S_TWAIT: begin
                if (w_d_done) begin
                    n_state = w_over ? ptrim_pkg::S_EMIT : ptrim_pkg::S_TSTEP;
                end
            end
            ptrim_pkg::S_TSTEP: begin
                if (r_q == QW'(0) || (r_q == QW'(1) && !r_evicted)) begin
                    n_state = ptrim_pkg::S_EMIT;
                end else begin
                    n_state = ptrim_pkg::S_TSRT;
                end
            end
            ptrim_pkg::S_EMIT:  if (w_emit && r_tbest == QW'(0)) n_state = ptrim_pkg::S_ELAST;
            ptrim_pkg::S_ELAST: if (w_elast) n_state = ptrim_pkg::S_IDLE;
            default:            n_state = ptrim_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptrim_pkg::S_IDLE;
            r_thr       <= '0;
            r_hcnt      <= '0;
            r_best      <= HW'(1);
            r_bdist     <= '0;
            r_hdone     <= 1'b0;
            r_tc        <= '0;
            r_evicted   <= 1'b0;
            r_k         <= '0;
            r_upto      <= '0;
            r_fin       <= 1'b0;
            r_q         <= '0;
            r_tbest     <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end

            if (w_shift && !(w_adm_ok && !w_full) || w_elast) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (w_adm_ok) begin
                if (w_full) begin
                    r_evicted <= 1'b1;
                end else begin
                    r_tc <= r_tc + TW'(1);
                end
            end

            case (r_state)
                ptrim_pkg::S_DEC: begin
                    if (!r_hdone) begin
                        if (!r_last) begin
                            r_hcnt <= r_hcnt + HW'(1);
                        end else if (r_hcnt != HW'(0)) begin
                            if (r_best >= r_hcnt) begin
                                r_best <= HW'(1);
                            end
                            r_upto <= r_hcnt;
                            r_fin  <= 1'b1;
                        end
                    end
                end
                ptrim_pkg::S_HWAIT: begin
                    if (w_d_done) begin
                        r_upto <= r_hcnt;
                        r_fin  <= 1'b0;
                        if (r_hcnt == HW'(2)) begin
                            r_bdist <= w_dist;
                            r_best  <= HW'(1);
                        end else if (!w_over && w_dist < r_bdist) begin
                            r_bdist <= w_dist;
                            r_best  <= w_i;
                        end
                    end
                end
                ptrim_pkg::S_RADM0: begin
                    if (w_adm_ok) begin
                        r_k     <= r_best;
                        r_hdone <= 1'b1;
                    end
                end
                ptrim_pkg::S_RADM: begin
                    if (w_adm_ok) begin
                        r_k <= r_k + HW'(1);
                    end
                end
                ptrim_pkg::S_FIN: begin
                    r_q     <= QW'(r_tc - TW'(1));
                    r_tbest <= QW'(r_tc - TW'(1));
                    r_first <= 1'b1;
                end
                ptrim_pkg::S_TWAIT: begin
                    if (w_d_done) begin
                        r_first <= 1'b0;
                        if (r_first) begin
                            r_bdist <= w_dist;
                        end else if (!w_over && w_dist < r_bdist) begin
                            r_bdist <= w_dist;
                            r_tbest <= r_q;
                        end
                    end
                end
                ptrim_pkg::S_TSTEP: begin
                    r_q <= r_q - QW'(1);
                end
                ptrim_pkg::S_EMIT: begin
                    if (w_emit) begin
                        r_tbest <= r_tbest - QW'(1);
                    end
                end
                ptrim_pkg::S_ELAST: begin
                    if (w_elast) begin
                        r_hcnt    <= '0;
                        r_best    <= HW'(1);
                        r_bdist   <= '0;
                        r_hdone   <= 1'b0;
                        r_tc      <= '0;
                        r_evicted <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out.x;
    assign o_out_y     = r_out.y;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

FILE: hdl/ptrim_checker.sv
// Port-level checks for the polyline end overshoot trim unit, with its bind.
// Depends on ptrim_pkg and polyline_end_overshoot_trim_unit.
`default_nettype none

module ptrim_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_in_valid,
    input wire logic                                  o_in_stall,
    input wire logic                                  o_out_valid,
    input wire logic                                  i_out_stall,
    input wire logic signed [ptrim_pkg::PT_COORD_BITS-1:0] o_out_x,
    input wire logic signed [ptrim_pkg::PT_COORD_BITS-1:0] o_out_y,
    input wire logic                                  o_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_last)))
        else $error("stalled output item changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while previous item still in work");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output item valid right after reset");

endmodule

bind polyline_end_overshoot_trim_unit ptrim_checker u_ptrim_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_x     (o_out_x),
    .o_out_y     (o_out_y),
    .o_out_last  (o_out_last)
);

`default_nettype wire

FILE: tb/polyline_end_overshoot_trim_unit_test.sv
// Testbench for polyline_end_overshoot_trim_unit: drives polylines, predicts the trimmed
// vertex stream in a behavioral model and checks each output item. Depends on ptrim_pkg.
`timescale 1ns / 100ps

module polyline_end_overshoot_trim_unit_test;

    localparam int CW  = ptrim_pkg::PT_COORD_BITS;
    localparam int THW = ptrim_pkg::PT_THR_W;
    localparam int WIN = ptrim_pkg::PT_WINDOW;
    localparam int CAP = ptrim_pkg::PT_TAIL_CAP;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 last;
    } t_item;

    typedef struct {
        logic signed [63:0] x;
        logic signed [63:0] y;
    } t_pt;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [CW-1:0] i_in_x = '0;
    logic signed [CW-1:0] i_in_y = '0;
    logic i_in_last = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [CW-1:0] o_out_x;
    logic signed [CW-1:0] o_out_y;
    logic o_out_last;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [THW-1:0] i_cfg_data = '0;

    polyline_end_overshoot_trim_unit uut (.*);

    t_item pending_q[$];
    t_item kept_q[$];
    int errors = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit in_taken = 1'b0;

    // trim model state
    logic [THW-1:0] snap_sq;
    t_pt  head_buf[WIN];
    int   head_n;
    int   best_idx;
    logic [63:0] best_d;
    bit   head_closed;
    t_pt  tail_buf[$];
    int   admitted;

    initial forever #5 i_clk = ~i_clk;

    function automatic logic [63:0] sq_dist(t_pt a, t_pt b);
        logic [63:0] dx, dy;
        dx = (a.x >= b.x) ? a.x - b.x : b.x - a.x;
        dy = (a.y >= b.y) ? a.y - b.y : b.y - a.y;
        return dx * dx + dy * dy;
    endfunction

    function automatic void push_kept(t_pt v, logic lst);
        t_item it;
        it.x = v.x[CW-1:0];
        it.y = v.y[CW-1:0];
        it.last = lst;
        kept_q.push_back(it);
    endfunction

    function automatic void line_reset();
        head_n = 0;
        best_idx = 1;
        best_d = 0;
        head_closed = 0;
        tail_buf.delete();
        admitted = 0;
    endfunction

    function automatic void admit_vtx(t_pt v);
        if (tail_buf.size() >= CAP) push_kept(tail_buf.pop_front(), 1'b0);
        tail_buf.push_back(v);
        if (admitted < 65535) admitted++;
    endfunction

    function automatic void close_head(int upto);
        int b;
        b = (best_idx < 1) ? 1 : best_idx;
        admit_vtx(head_buf[0]);
        for (int k = b; k < upto && k < WIN; k++) admit_vtx(head_buf[k]);
        head_closed = 1;
    endfunction

    function automatic void finish_line(t_pt lv);
        int cnt, best, base, q;
        logic [63:0] cur, d;
        cnt = tail_buf.size();
        if (cnt > 0) begin
            best = cnt - 1;
            cur = sq_dist(tail_buf[best], lv);
            base = admitted - cnt;
            if (cur <= snap_sq) begin
                q = cnt - 1;
                while (q > 0) begin
                    q--;
                    if (base + q == 0) break;
                    d = sq_dist(tail_buf[q], lv);
                    if (d > snap_sq) break;
                    if (d < cur) begin
                        cur = d;
                        best = q;
                    end
                end
            end
            for (int k = 0; k <= best; k++) push_kept(tail_buf[k], 1'b0);
        end
        push_kept(lv, 1'b1);
        line_reset();
    endfunction

    function automatic void predict_trim(t_item it);
        t_pt v;
        int i;
        logic [63:0] d;
        v.x = 64'(it.x);
        v.y = 64'(it.y);
        if (head_closed || head_n >= WIN) begin
            if (!head_closed) close_head(head_n);
            if (it.last) finish_line(v);
            else admit_vtx(v);
            return;
        end
        i = head_n;
        head_buf[i] = v;
        head_n = i + 1;
        if (it.last) begin
            if (i != 0) begin
                if (best_idx >= i) best_idx = 1;
                close_head(i);
            end
            finish_line(v);
            return;
        end
        if (i == 1) begin
            best_d = sq_dist(v, head_buf[0]);
            best_idx = 1;
            if (best_d > snap_sq) close_head(2);
        end else if (i >= 2) begin
            d = sq_dist(v, head_buf[0]);
            if (d > snap_sq) begin
                close_head(i + 1);
            end else begin
                if (d < best_d) begin
                    best_d = d;
                    best_idx = i;
                end
                if (i >= WIN - 1) close_head(i + 1);
            end
        end
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_x <= pending_q[0].x;
                    i_in_y <= pending_q[0].y;
                    i_in_last <= pending_q[0].last;
                    predict_trim(pending_q.pop_front());
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (o_out_valid) stall_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_item e;
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (kept_q.size() == 0) begin
                $display("%0t unexpected item x=%0d y=%0d last=%0b", $time, o_out_x, o_out_y,
                         o_out_last);
                errors++;
            end else begin
                e = kept_q.pop_front();
                if (e.x !== o_out_x || e.y !== o_out_y || e.last !== o_out_last) begin
                    $display("%0t mismatch exp x=%0d y=%0d last=%0b act x=%0d y=%0d last=%0b",
                             $time, e.x, e.y, e.last, o_out_x, o_out_y, o_out_last);
                    errors++;
                end
            end
        end
    end

    task automatic write_snap(logic [THW-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        snap_sq = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_out();
        while (pending_q.size() > 0 || i_in_valid || kept_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic queue_vtx(int x, int y, bit lst);
        t_item it;
        it.x = x[CW-1:0];
        it.y = y[CW-1:0];
        it.last = lst;
        pending_q.push_back(it);
    endtask

    // well-formed line with overshoot near both ends and random noise
    task automatic queue_line(int len, int spread, int step);
        int bx, by, ex, ey;
        bx = $urandom_range(0, 2000000) - 1000000;
        by = $urandom_range(0, 2000000) - 1000000;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 7) == 0)
                queue_vtx($urandom, $urandom, k == len - 1);
            else if (k < 6 || k >= len - 6)
                queue_vtx(bx + ((k < 6) ? 0 : step * 3) + $urandom_range(0, 2 * spread) - spread,
                          by + $urandom_range(0, 2 * spread) - spread, k == len - 1);
            else
                queue_vtx(bx + step * (k % 5), by + step * (k % 3), k == len - 1);
        end
    endtask

    initial begin
        int lens;
        line_reset();
        snap_sq = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, single and two vertex lines, ties, last inside window
        queue_vtx(-8388608, 8388607, 1);
        queue_vtx(8388607, -8388608, 0);
        queue_vtx(-8388608, 8388607, 1);
        queue_vtx(0, 0, 0);
        queue_vtx(5, 5, 0);
        queue_vtx(1, 1, 0);
        queue_vtx(1, 1, 0);
        queue_vtx(7, 7, 1);
        drain_out();
        write_snap(49'd100);
        queue_vtx(0, 0, 0);
        queue_vtx(3, 0, 0);
        queue_vtx(1, 1, 0);
        queue_vtx(-1, -1, 0);
        queue_vtx(50, 50, 0);
        queue_vtx(9, 9, 0);
        queue_vtx(2, 2, 0);
        queue_vtx(1, 1, 1);
        queue_vtx(-8388608, -8388608, 0);
        queue_vtx(8388607, 8388607, 1);
        drain_out();
        write_snap({THW{1'b1}});
        for (int k = 0; k < 24; k++) queue_vtx($urandom, $urandom, k == 23);
        drain_out();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_snap(49'd0);
                1: write_snap(49'd400);
                2: write_snap(THW'({$urandom, $urandom}));
                default: write_snap(49'd40000);
            endcase
            for (int n = 0; n < 90; n += lens) begin
                lens = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 45);
                queue_line(lens, (ph == 3) ? 150 : 15, $urandom_range(1, 500));
            end
            drain_out();
        end

        if (errors == 0)
            $display("polyline_end_overshoot_trim_unit_test: PASS");
        else
            $display("polyline_end_overshoot_trim_unit_test: FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("polyline_end_overshoot_trim_unit_test: FAIL");
        $finish;
    end
endmodule
